/* rtl/pcsb_pkg.sv */
// ----------------------------------------------------------------------------
// pcsb_pkg
// Shared types, codes and constants for the point cloud scan binning block.
// ----------------------------------------------------------------------------
package pcsb_pkg;

  // table depth and CORDIC iteration count
  localparam int NUM_BINS     = 512;
  localparam int CORDIC_STEPS = 16;
  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int CNT_W        = 5;

  localparam logic [16:0] RANGE_INF = 17'h1ffff;

  // item function codes
  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_POINT = 2'd1,
    FN_READ  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  // result source codes
  localparam logic [1:0] SRC_EMPTY = 2'd0;
  localparam logic [1:0] SRC_3D    = 2'd1;
  localparam logic [1:0] SRC_2D    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_GROUND   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [1:0] ST_NOTCLOSE = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ANGLE_LOW  = 3'd0;
  localparam logic [2:0] CFG_ANGLE_HIGH = 3'd1;
  localparam logic [2:0] CFG_ANGLE_STEP = 3'd2;
  localparam logic [2:0] CFG_RANGE_LOW  = 3'd3;
  localparam logic [2:0] CFG_RANGE_HIGH = 3'd4;
  localparam logic [2:0] CFG_GROUND     = 3'd5;
  localparam logic [2:0] CFG_BINS_USED  = 3'd6;

  // one scan table entry
  typedef struct packed {
    logic        hit;
    logic [16:0] range;
  } entry_t;

  // round(atan(2^-i) * 32768 / pi)
  function automatic logic [13:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [13:0] v;
    unique case (i)
      5'd0:    v = 14'd8192;
      5'd1:    v = 14'd4836;
      5'd2:    v = 14'd2555;
      5'd3:    v = 14'd1297;
      5'd4:    v = 14'd651;
      5'd5:    v = 14'd326;
      5'd6:    v = 14'd163;
      5'd7:    v = 14'd81;
      5'd8:    v = 14'd41;
      5'd9:    v = 14'd20;
      5'd10:   v = 14'd10;
      5'd11:   v = 14'd5;
      5'd12:   v = 14'd3;
      5'd13:   v = 14'd1;
      5'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/pcsb_table.sv */
// ----------------------------------------------------------------------------
// pcsb_table
// Scan table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcsb_table
  import pcsb_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [BIN_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [BIN_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [NUM_BINS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pcsb_cordic.sv */
// ----------------------------------------------------------------------------
// pcsb_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module pcsb_cordic
  import pcsb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic               busy,
  output logic signed [15:0] angle
);

  logic signed [27:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [18:0] z_r, z_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               zero_r, zero_nxt;
  logic signed [27:0] x0, y0, sx, sy;
  logic signed [18:0] at;

  assign x0 = {{4{x[15]}}, x, 8'd0};
  assign y0 = {{4{y[15]}}, y, 8'd0};
  assign sx = cx_r >>> cnt_r;
  assign sy = cy_r >>> cnt_r;
  assign at = signed'({5'd0, atan_lut(cnt_r)});

  // pre-rotation on start, then one shared shift-add step per cycle
  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (x == 16'sd0) && (y == 16'sd0);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      if (x[15]) begin
        if (!y[15]) begin
          cx_nxt = y0;
          cy_nxt = -x0;
          z_nxt  = 19'sd16384;
        end else begin
          cx_nxt = -y0;
          cy_nxt = x0;
          z_nxt  = -19'sd16384;
        end
      end else begin
        cx_nxt = x0;
        cy_nxt = y0;
        z_nxt  = '0;
      end
    end else if (busy_r) begin
      if (!cy_r[27]) begin
        cx_nxt = cx_r + sy;
        cy_nxt = cy_r - sx;
        z_nxt  = z_r + at;
      end else begin
        cx_nxt = cx_r - sy;
        cy_nxt = cy_r + sx;
        z_nxt  = z_r - at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  // saturate to the 16 bit angle range; origin reads as zero
  always_comb begin
    if (zero_r) begin
      angle = '0;
    end else if (z_r > 19'sd32767) begin
      angle = 16'sd32767;
    end else if (z_r < -19'sd32768) begin
      angle = -16'sd32768;
    end else begin
      angle = z_r[15:0];
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/pcsb_divsqrt.sv */
// ----------------------------------------------------------------------------
// pcsb_divsqrt
// Radix-2 restoring divider and digit-by-digit square root, run side by
// side, one quotient bit and one root bit per cycle.
// ----------------------------------------------------------------------------
module pcsb_divsqrt
  import pcsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  input  logic [31:0] rad,
  output logic        busy,
  output logic [15:0] quot,
  output logic [15:0] root
);

  logic [15:0] n_r, n_nxt, q_r, q_nxt, den_r, den_nxt;
  logic [16:0] drem_r, drem_nxt;
  logic [31:0] rad_r, rad_nxt;
  logic [15:0] root_r, root_nxt;
  logic [19:0] srem_r, srem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] rs;
  logic [19:0] ss, trial;

  assign rs    = {drem_r[15:0], n_r[15]};
  assign ss    = {srem_r[17:0], rad_r[31:30]};
  assign trial = {2'b00, root_r, 2'b01};

  always_comb begin
    n_nxt    = n_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    drem_nxt = drem_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    srem_nxt = srem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      n_nxt    = num;
      den_nxt  = den;
      q_nxt    = '0;
      drem_nxt = '0;
      rad_nxt  = rad;
      root_nxt = '0;
      srem_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // divider step
      n_nxt = {n_r[14:0], 1'b0};
      if (rs >= {1'b0, den_r}) begin
        drem_nxt = rs - {1'b0, den_r};
        q_nxt    = {q_r[14:0], 1'b1};
      end else begin
        drem_nxt = rs;
        q_nxt    = {q_r[14:0], 1'b0};
      end
      // square root step
      rad_nxt = {rad_r[29:0], 2'b00};
      if (ss >= trial) begin
        srem_nxt = ss - trial;
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        srem_nxt = ss;
        root_nxt = {root_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r    <= n_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
    drem_r <= drem_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign root = root_r;

endmodule

/* rtl/point_cloud_to_scan_binning_top.sv */
// ----------------------------------------------------------------------------
// point_cloud_to_scan_binning_top
// Bins 3D points into a nearest-range scan table; clears and reads bins.
// ----------------------------------------------------------------------------
// One item at a time. A point above ground passes these states in order:
//   - the CORDIC state: 16 steps, until the state sees the unit finish.
//     The squares and window squares run on the shared multiplier
//     meanwhile.
//   - the window check.
//   - the side-by-side divider and square root.
//   - the table read and the update.
//   - the hand-off of the result to the output register.
// A point that fails the distance or angle window leaves for the hand-off
// at the check; one whose bin is past the bin count leaves after the
// divider. A ground point or a no-op goes straight to the hand-off, a bin
// read passes a table read and a merge first. A clear item sweeps the
// 512-entry table one entry per cycle. The same sweep runs after reset,
// and no item is taken during it. Configuration writes are taken at any
// time. The result register lets a new item enter while the last result
// waits; a second result stalls until out_tready frees that register.
module point_cloud_to_scan_binning_top
  import pcsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic [79:0] in_tdata,   // [15:0] point_x, [31:16] point_y, [47:32] point_z,
                                  // [56:48] read_bin, [73:57] planar_range_2d, zero pad
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [3:0]  out_tuser,  // [1:0] source, [3:2] status
  output logic [31:0] out_tdata,  // [8:0] bin_index, [25:9] range_mm, zero pad
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CRD, S_CHK, S_DIV, S_BIN, S_PUPD, S_RRD, S_RMRG, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [15:0] angle_low_r, angle_high_r, ground_r;
  logic [15:0]        angle_step_r, range_low_r, range_high_r;
  logic [9:0]         bins_used_r;

  // latched item
  logic [1:0]         func_r;
  logic signed [15:0] px_r, py_r;
  logic [8:0]         rbin_r;
  logic [16:0]        r2d_r;

  // arithmetic
  logic [2:0]         mcnt_r, mcnt_nxt;
  logic [31:0]        d2_r, lo2_r, hi2_r;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic               clr_reply_r, clr_reply_nxt;
  logic [BIN_W-1:0]   clr_cnt_r, clr_cnt_nxt;

  // result staging and output register
  logic [8:0]         res_bin_r, res_bin_nxt;
  logic [16:0]        res_rng_r, res_rng_nxt;
  logic [1:0]         res_src_r, res_src_nxt, res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [8:0]         o_bin_r;
  logic [16:0]        o_rng_r;
  logic [1:0]         o_src_r, o_st_r;

  // submodule links
  logic               cor_start, cor_busy, ds_start, ds_busy;
  logic signed [15:0] angle;
  logic [15:0]        quot, root, ds_num, ds_den, used;
  logic [16:0]        adiff;
  logic               we;
  logic [BIN_W-1:0]   waddr, raddr;
  entry_t             wdata, rdata;
  logic [11:0]        rbin_ext;
  logic               rbin_ok, in_acc, load_out;
  logic signed [15:0] in_z;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_z      = in_tdata[47:32];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_low_r  <= -16'sd32768;
      angle_high_r <= 16'sd32767;
      angle_step_r <= 16'd182;
      range_low_r  <= 16'd100;
      range_high_r <= 16'd10000;
      ground_r     <= 16'sd50;
      bins_used_r  <= 10'd361;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ANGLE_LOW:  angle_low_r  <= cfg_data;
        CFG_ANGLE_HIGH: angle_high_r <= cfg_data;
        CFG_ANGLE_STEP: angle_step_r <= cfg_data;
        CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        CFG_RANGE_HIGH: range_high_r <= cfg_data;
        CFG_GROUND:     ground_r     <= cfg_data;
        CFG_BINS_USED:  bins_used_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // latch the item on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      px_r   <= in_tdata[15:0];
      py_r   <= in_tdata[31:16];
      rbin_r <= in_tdata[56:48];
      r2d_r  <= in_tdata[73:57];
    end
  end

  // shared multiplier: x^2, y^2, low^2, high^2 in turn
  always_comb begin
    unique case (mcnt_r[1:0])
      2'd0:    begin ma = {px_r[15], px_r}; mb = {px_r[15], px_r}; end
      2'd1:    begin ma = {py_r[15], py_r}; mb = {py_r[15], py_r}; end
      2'd2:    begin ma = {1'b0, range_low_r}; mb = {1'b0, range_low_r}; end
      default: begin ma = {1'b0, range_high_r}; mb = {1'b0, range_high_r}; end
    endcase
  end
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (state_r == S_CRD && !mcnt_r[2]) begin
      unique case (mcnt_r[1:0])
        2'd0:    d2_r  <= prod[31:0];
        2'd1:    d2_r  <= d2_r + prod[31:0];
        2'd2:    lo2_r <= prod[31:0];
        default: hi2_r <= prod[31:0];
      endcase
    end
  end

  pcsb_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x     (in_tdata[15:0]),
    .y     (in_tdata[31:16]),
    .busy  (cor_busy),
    .angle (angle)
  );

  // bin numerator is non-negative once the angle passed the window
  assign adiff  = {angle[15], angle} - {angle_low_r[15], angle_low_r};
  assign ds_num = adiff[15:0];
  assign ds_den = (angle_step_r == 16'd0) ? 16'd1 : angle_step_r;

  pcsb_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ds_start),
    .num   (ds_num),
    .den   (ds_den),
    .rad   (d2_r),
    .busy  (ds_busy),
    .quot  (quot),
    .root  (root)
  );

  assign used = ({6'd0, bins_used_r} > 16'(NUM_BINS)) ? 16'(NUM_BINS)
                                                       : {6'd0, bins_used_r};
  assign rbin_ext = {3'd0, rbin_r};
  assign rbin_ok  = ({3'd0, rbin_r} < 12'(NUM_BINS));
  assign raddr    = (state_r == S_BIN) ? quot[BIN_W-1:0] : rbin_ext[BIN_W-1:0];

  pcsb_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mcnt_nxt      = mcnt_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    res_bin_nxt   = res_bin_r;
    res_rng_nxt   = res_rng_r;
    res_src_nxt   = res_src_r;
    res_st_nxt    = res_st_r;
    cor_start     = 1'b0;
    ds_start      = 1'b0;
    we            = 1'b0;
    waddr         = clr_cnt_r;
    wdata         = '{hit: 1'b0, range: RANGE_INF};
    unique case (state_r)
      // refill the table with infinity
      S_CLR: begin
        we          = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == BIN_W'(NUM_BINS - 1)) begin
          state_nxt = clr_reply_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        res_bin_nxt = '0;
        res_rng_nxt = RANGE_INF;
        res_src_nxt = SRC_EMPTY;
        res_st_nxt  = ST_DONE;
        if (in_acc) begin
          unique case (func_t'(in_tuser))
            FN_CLEAR: begin
              clr_cnt_nxt   = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            FN_POINT: begin
              if (in_z <= ground_r) begin
                res_st_nxt = ST_GROUND;
                state_nxt  = S_OUT;
              end else begin
                cor_start = 1'b1;
                mcnt_nxt  = '0;
                state_nxt = S_CRD;
              end
            end
            FN_READ: state_nxt = S_RRD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_CRD: begin
        if (!mcnt_r[2]) begin
          mcnt_nxt = mcnt_r + 1'b1;
        end
        if (!cor_busy) begin
          state_nxt = S_CHK;
        end
      end
      // distance and angle window
      S_CHK: begin
        if (d2_r < lo2_r || d2_r > hi2_r || angle < angle_low_r ||
            angle > angle_high_r) begin
          res_st_nxt = ST_OUTSIDE;
          state_nxt  = S_OUT;
        end else begin
          ds_start  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!ds_busy) begin
          state_nxt = S_BIN;
        end
      end
      // table read is issued here at the quotient
      S_BIN: begin
        if (quot >= used) begin
          res_st_nxt = ST_OUTSIDE;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_PUPD;
        end
      end
      S_PUPD: begin
        res_bin_nxt = quot[8:0];
        if ({1'b0, root} < rdata.range) begin
          we          = 1'b1;
          waddr       = quot[BIN_W-1:0];
          wdata       = '{hit: 1'b1, range: {1'b0, root}};
          res_rng_nxt = {1'b0, root};
          res_src_nxt = SRC_3D;
          res_st_nxt  = ST_DONE;
        end else begin
          res_rng_nxt = rdata.range;
          res_src_nxt = rdata.hit ? SRC_3D : SRC_EMPTY;
          res_st_nxt  = ST_NOTCLOSE;
        end
        state_nxt = S_OUT;
      end
      S_RRD: state_nxt = S_RMRG;
      // merge the stored bin with the 2D range
      S_RMRG: begin
        res_bin_nxt = rbin_r;
        res_st_nxt  = ST_DONE;
        if (rbin_ok) begin
          res_rng_nxt = rdata.range;
          res_src_nxt = rdata.hit ? SRC_3D : SRC_EMPTY;
        end else begin
          res_rng_nxt = RANGE_INF;
          res_src_nxt = SRC_EMPTY;
        end
        if (r2d_r != RANGE_INF &&
            (!rbin_ok || rdata.range == RANGE_INF || r2d_r < rdata.range)) begin
          res_rng_nxt = r2d_r;
          res_src_nxt = SRC_2D;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        clr_reply_nxt = 1'b0;
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_bin_r <= res_bin_nxt;
    res_rng_r <= res_rng_nxt;
    res_src_r <= res_src_nxt;
    res_st_r  <= res_st_nxt;
    if (load_out) begin
      o_bin_r <= res_bin_r;
      o_rng_r <= res_rng_r;
      o_src_r <= res_src_r;
      o_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, o_rng_r, o_bin_r};
  assign out_tuser  = {o_st_r, o_src_r};

endmodule
